>>> rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants and types for the DDA line rasteriser: coordinate and
// fixed-point widths, sequencer state codes and the divider request.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // Coordinate and fixed-point formats
  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PIX_W      = 6;   // width of the pixel ports
  localparam int unsigned ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned INC_W      = FRAC_BITS + 1;  // increment magnitude
  localparam int unsigned DCNT_W     = $clog2(ACC_W);

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVX = 2'd1;
  localparam logic [1:0] ST_DIVY = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // Request into the shared divider
  typedef struct packed {
    logic                  start;
    logic [ACC_W-1:0]      dividend;
    logic [COORD_BITS-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/dlr_div.sv
// ----------------------------------------------------------------------------
// dlr_div
// Restoring divider, one quotient bit per cycle. After the last step it
// pulses done for one cycle with the quotient held until the next request.
// ----------------------------------------------------------------------------
module dlr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dlr_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [dlr_pkg::INC_W-1:0] quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [dlr_pkg::DCNT_W-1:0]      cnt_q, cnt_d;
  logic [dlr_pkg::ACC_W-1:0]       quot_q, quot_d;
  logic [dlr_pkg::COORD_BITS-1:0]  rem_q, rem_d;
  logic [dlr_pkg::COORD_BITS-1:0]  dvsr_q, dvsr_d;
  logic [dlr_pkg::COORD_BITS:0]    shifted;
  logic [dlr_pkg::COORD_BITS:0]    trial;
  logic                            fits;

  // One restoring step: bring in the next dividend bit, try to subtract
  assign shifted = {rem_q, quot_q[dlr_pkg::ACC_W-1]};
  assign trial   = shifted - {1'b0, dvsr_q};
  assign fits    = (shifted >= {1'b0, dvsr_q});

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = dlr_pkg::DCNT_W'(dlr_pkg::ACC_W - 1);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvsr_d = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[dlr_pkg::ACC_W-2:0], fits};
      rem_d  = fits ? trial[dlr_pkg::COORD_BITS-1:0] : shifted[dlr_pkg::COORD_BITS-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  // Quotient never exceeds 1.0 in Q.FRAC_BITS
  assign done_o = done_q;
  assign quot_o = quot_q[dlr_pkg::INC_W-1:0];

endmodule

>>> rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasteriser: one line request in, steps+1 pixels out, one a cycle.
// ----------------------------------------------------------------------------
// A request with distinct endpoints runs two divisions in the shared divider
//   (x increment, then y increment), then emits pixels.
// A new line is accepted only in idle, after busy has fallen at the end of the
//   previous line; a single-point line emits its pixel in the cycle after
//   acceptance. The receiver cannot stall.
// Reset is asynchronous, active low, and returns the block to idle.
module dda_line_rasterizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [5:0]                 start_x_i,
  input  logic [5:0]                 start_y_i,
  input  logic [5:0]                 end_x_i,
  input  logic [5:0]                 end_y_i,
  input  logic [31:0]                pixel_color_i,
  output logic                       pixel_valid_o,
  output logic [dlr_pkg::PIX_W-1:0]  pixel_x_o,
  output logic [dlr_pkg::PIX_W-1:0]  pixel_y_o,
  output logic [31:0]                out_color_o,
  output logic                       last_pixel_o
);

  localparam logic [dlr_pkg::ACC_W-1:0] HALF =
    dlr_pkg::ACC_W'(1) << (dlr_pkg::FRAC_BITS - 1);

  logic [1:0]                       state_q, state_d;
  logic [dlr_pkg::COORD_BITS-1:0]   steps_q, steps_d;
  logic [dlr_pkg::COORD_BITS-1:0]   cnt_q, cnt_d;
  logic [dlr_pkg::COORD_BITS-1:0]   ady_q, ady_d;
  logic                             negx_q, negx_d, negy_q, negy_d;
  logic [dlr_pkg::INC_W-1:0]        incx_q, incx_d, incy_q, incy_d;
  logic [dlr_pkg::ACC_W-1:0]        accx_q, accx_d, accy_q, accy_d;
  logic [31:0]                      color_q, color_d;

  logic [dlr_pkg::COORD_BITS-1:0]   x0, y0, x1, y1, adx, ady, steps;
  logic                             accept;
  logic [dlr_pkg::ACC_W-1:0]        rndx, rndy, stepx, stepy;
  dlr_pkg::div_req_t                div_req;
  logic                             div_done;
  logic [dlr_pkg::INC_W-1:0]        div_quot;

  // Request decode: masked endpoints, deltas and step count
  assign x0     = start_x_i[dlr_pkg::COORD_BITS-1:0];
  assign y0     = start_y_i[dlr_pkg::COORD_BITS-1:0];
  assign x1     = end_x_i[dlr_pkg::COORD_BITS-1:0];
  assign y1     = end_y_i[dlr_pkg::COORD_BITS-1:0];
  assign adx    = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
  assign ady    = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
  assign steps  = (adx > ady) ? adx : ady;
  assign accept = start && (state_q == dlr_pkg::ST_IDLE);

  // Shared divider
  dlr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Signed increments applied to the accumulators
  assign stepx = negx_q ? (accx_q - dlr_pkg::ACC_W'(incx_q))
                        : (accx_q + dlr_pkg::ACC_W'(incx_q));
  assign stepy = negy_q ? (accy_q - dlr_pkg::ACC_W'(incy_q))
                        : (accy_q + dlr_pkg::ACC_W'(incy_q));

  // Sequencer
  always_comb begin
    state_d  = state_q;
    steps_d  = steps_q;
    cnt_d    = cnt_q;
    ady_d    = ady_q;
    negx_d   = negx_q;
    negy_d   = negy_q;
    incx_d   = incx_q;
    incy_d   = incy_q;
    accx_d   = accx_q;
    accy_d   = accy_q;
    color_d  = color_q;
    div_req  = '0;
    unique case (state_q)
      dlr_pkg::ST_IDLE: begin
        if (accept) begin
          steps_d = steps;
          cnt_d   = '0;
          ady_d   = ady;
          negx_d  = (x1 < x0);
          negy_d  = (y1 < y0);
          incx_d  = '0;
          incy_d  = '0;
          accx_d  = {x0, {dlr_pkg::FRAC_BITS{1'b0}}};
          accy_d  = {y0, {dlr_pkg::FRAC_BITS{1'b0}}};
          color_d = pixel_color_i;
          if (steps == '0) begin
            state_d = dlr_pkg::ST_EMIT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {adx, {dlr_pkg::FRAC_BITS{1'b0}}};
            div_req.divisor  = steps;
            state_d          = dlr_pkg::ST_DIVX;
          end
        end
      end
      dlr_pkg::ST_DIVX: begin
        if (div_done) begin
          incx_d           = div_quot;
          div_req.start    = 1'b1;
          div_req.dividend = {ady_q, {dlr_pkg::FRAC_BITS{1'b0}}};
          div_req.divisor  = steps_q;
          state_d          = dlr_pkg::ST_DIVY;
        end
      end
      dlr_pkg::ST_DIVY: begin
        if (div_done) begin
          incy_d  = div_quot;
          state_d = dlr_pkg::ST_EMIT;
        end
      end
      dlr_pkg::ST_EMIT: begin
        accx_d = stepx;
        accy_d = stepy;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == steps_q) begin
          state_d = dlr_pkg::ST_IDLE;
        end
      end
      default: state_d = dlr_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlr_pkg::ST_IDLE;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ady_q   <= ady_d;
    negx_q  <= negx_d;
    negy_q  <= negy_d;
    incx_q  <= incx_d;
    incy_q  <= incy_d;
    accx_q  <= accx_d;
    accy_q  <= accy_d;
    color_q <= color_d;
  end

  // Pixel output: accumulators rounded half up
  assign rndx          = accx_q + HALF;
  assign rndy          = accy_q + HALF;
  assign busy          = (state_q != dlr_pkg::ST_IDLE);
  assign pixel_valid_o = (state_q == dlr_pkg::ST_EMIT);
  assign pixel_x_o     = dlr_pkg::PIX_W'(rndx[dlr_pkg::ACC_W-1:dlr_pkg::FRAC_BITS]);
  assign pixel_y_o     = dlr_pkg::PIX_W'(rndy[dlr_pkg::ACC_W-1:dlr_pkg::FRAC_BITS]);
  assign out_color_o   = color_q;
  assign last_pixel_o  = (cnt_q == steps_q);

endmodule
